>>> src/dwps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwps_pkg
// Shared widths, register codes and the configuration record for the
// two-wheel PI speed controller.
// ----------------------------------------------------------------------------
package dwps_pkg;

  // Speed field width (signed); the error, sync, sum and stream widths below derive from it.
  localparam int SPEED_BITS = 16;

  // Fixed register and result widths
  localparam int GAIN_W     = 10;
  localparam int LIMIT_W    = 15;
  localparam int DUTY_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Integrator is clamped to +-limit, so one sign bit over the limit suffices
  localparam int INT_W       = LIMIT_W + 1;
  localparam int ERR_W       = SPEED_BITS + 1;
  localparam int ACC_W       = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;
  localparam int SYNC_DIFF_W = SPEED_BITS + 2;
  localparam int P_PROD_W    = GAIN_W + 1 + ERR_W;
  localparam int I_PROD_W    = GAIN_W + 1 + INT_W;
  localparam int CORR_W      = ((P_PROD_W > I_PROD_W) ? P_PROD_W : I_PROD_W) + 1;
  localparam int SYNC_W      = GAIN_W + 1 + SYNC_DIFF_W;
  localparam int SUM_PRE_W   = (CORR_W > SYNC_W) ? CORR_W : SYNC_W;
  localparam int SUM_W       = ((SUM_PRE_W > DUTY_W + 1) ? SUM_PRE_W : DUTY_W + 1) + 2;

  // Stream payload widths
  localparam int IN_DATA_W  = ((4 * SPEED_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * DUTY_W + 7) / 8) * 8;

  // Reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = GAIN_W'(1);
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = GAIN_W'(1);
  localparam logic [GAIN_W-1:0]  SYNC_GAIN_RST   = GAIN_W'(1);
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = LIMIT_W'(500);
  localparam logic [DUTY_W-1:0]  BASE_DUTY_RST   = DUTY_W'(500);
  localparam logic [DUTY_W-1:0]  DUTY_MAX_RST    = DUTY_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_SYNC_GAIN   = 3'd2,
    CFG_INTEG_LIMIT = 3'd3,
    CFG_BASE_DUTY   = 3'd4,
    CFG_DUTY_MAX    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  sync_gain;
    logic [LIMIT_W-1:0] integ_limit;
    logic [DUTY_W-1:0]  base_duty;
    logic [DUTY_W-1:0]  duty_max;
  } cfg_t;

endpackage

>>> src/dwps_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwps_cfg
// Control register file; write-only, data masked to each register's width.
// ----------------------------------------------------------------------------
module dwps_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dwps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dwps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output dwps_pkg::cfg_t                 cfg_o
);
  import dwps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROP_GAIN:   cfg_d.prop_gain   = cfg_wdata_i[GAIN_W-1:0];
        CFG_INTEG_GAIN:  cfg_d.integ_gain  = cfg_wdata_i[GAIN_W-1:0];
        CFG_SYNC_GAIN:   cfg_d.sync_gain   = cfg_wdata_i[GAIN_W-1:0];
        CFG_INTEG_LIMIT: cfg_d.integ_limit = cfg_wdata_i[LIMIT_W-1:0];
        CFG_BASE_DUTY:   cfg_d.base_duty   = cfg_wdata_i[DUTY_W-1:0];
        CFG_DUTY_MAX:    cfg_d.duty_max    = cfg_wdata_i[DUTY_W-1:0];
        default:         cfg_d = cfg_q;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= PROP_GAIN_RST;
      cfg_q.integ_gain  <= INTEG_GAIN_RST;
      cfg_q.sync_gain   <= SYNC_GAIN_RST;
      cfg_q.integ_limit <= INTEG_LIMIT_RST;
      cfg_q.base_duty   <= BASE_DUTY_RST;
      cfg_q.duty_max    <= DUTY_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/dwps_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwps_wheel
// One wheel's PI term: integrator register with symmetric clamp, plus
// proportional and integral products.
// ----------------------------------------------------------------------------
module dwps_wheel (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  update_i,
  input  logic                                  clear_i,
  input  logic signed [dwps_pkg::SPEED_BITS-1:0] target_i,
  input  logic signed [dwps_pkg::SPEED_BITS-1:0] measured_i,
  input  dwps_pkg::cfg_t                        cfg_i,
  output logic signed [dwps_pkg::CORR_W-1:0]    corr_o
);
  import dwps_pkg::*;

  logic signed [INT_W-1:0]    integ_q, integ_d, integ_clamped;
  logic signed [ERR_W-1:0]    err;
  logic signed [ACC_W-1:0]    acc, lim, neg_lim;
  logic signed [P_PROD_W-1:0] p_prod;
  logic signed [I_PROD_W-1:0] i_prod;

  assign err     = ERR_W'(target_i) - ERR_W'(measured_i);
  assign acc     = ACC_W'(integ_q) + ACC_W'(err);
  assign lim     = ACC_W'($signed({1'b0, cfg_i.integ_limit}));
  assign neg_lim = -lim;

  // |clamped| <= limit, so it always fits the integrator width
  always_comb begin
    if (acc > lim) begin
      integ_clamped = lim[INT_W-1:0];
    end else if (acc < neg_lim) begin
      integ_clamped = neg_lim[INT_W-1:0];
    end else begin
      integ_clamped = acc[INT_W-1:0];
    end
  end

  always_comb begin
    integ_d = integ_q;
    if (clear_i) begin
      integ_d = '0;
    end else if (update_i) begin
      integ_d = integ_clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else begin
      integ_q <= integ_d;
    end
  end

  assign p_prod = P_PROD_W'($signed({1'b0, cfg_i.prop_gain})) * P_PROD_W'(err);
  assign i_prod = I_PROD_W'($signed({1'b0, cfg_i.integ_gain})) * I_PROD_W'(integ_clamped);
  assign corr_o = CORR_W'(p_prod) + CORR_W'(i_prod);

`ifndef SYNTHESIS
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> integ_q == '0)
    else $error("integrator not cleared after stop");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!clear_i && !update_i) |=> $stable(integ_q))
    else $error("integrator moved without an update");
`endif

endmodule

>>> src/dual_wheel_pi_speed_sync.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_pi_speed_sync
// Cross-coupled PI speed control for a left and a right wheel.
//
//   Channel  Dir  Handshake                  Payload
//   s_axis   in   s_axis_tvalid/tready       tdata: left_target, right_target,
//                                              left_measured, right_measured
//   m_axis   out  m_axis_tvalid/tready       tdata: left_drive, right_drive
//                                            tuser: stopped
//   cfg      in   cfg_we (no wait)           cfg_idx, cfg_wdata
//
// One request per cycle unless the output stalls; each request passes the
// input register, then the result register. The per-step work is one pass of
// error, integrator add/clamp, gain multiply and duty clamp; only the
// integrator add/clamp closes a loop from one request to the next.
// Reset clears both integrators, loads register defaults and empties both
// pipeline registers. A stalled output holds its result; the input register
// still takes a request while the output slot can drain or is empty.
// ----------------------------------------------------------------------------
module dual_wheel_pi_speed_sync (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [SB-1:0] left_target, [2SB-1:SB] right_target,
  // [3SB-1:2SB] left_measured, [4SB-1:3SB] right_measured (SB = SPEED_BITS)
  input  logic [dwps_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [15:0] left_drive, [31:16] right_drive
  output logic [dwps_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // [0] stopped
  output logic                              m_axis_tuser_o,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [dwps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dwps_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import dwps_pkg::*;

  cfg_t cfg;

  // Input register
  logic                          in_valid_q, in_valid_d;
  logic signed [SPEED_BITS-1:0]  lt_q, rt_q, lm_q, rm_q;

  // Result register
  logic                          out_valid_q, out_valid_d;
  logic [DUTY_W-1:0]             left_drive_q, left_drive_d;
  logic [DUTY_W-1:0]             right_drive_q, right_drive_d;
  logic                          stopped_q, stopped_d;

  logic                          advance, fire, take, stop;
  logic signed [CORR_W-1:0]      lcorr, rcorr;
  logic signed [SYNC_DIFF_W-1:0] sync_diff;
  logic signed [SYNC_W-1:0]      sync_term;
  logic signed [SUM_W-1:0]       left_sum, right_sum, duty_max_ext;

  dwps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // --- handshake ------------------------------------------------------------
  assign advance         = !out_valid_q || m_axis_tready_i;   // result slot free
  assign fire            = in_valid_q && advance;             // step executes
  assign s_axis_tready_o = !in_valid_q || advance;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      lt_q <= s_axis_tdata_i[SPEED_BITS-1:0];
      rt_q <= s_axis_tdata_i[2*SPEED_BITS-1:SPEED_BITS];
      lm_q <= s_axis_tdata_i[3*SPEED_BITS-1:2*SPEED_BITS];
      rm_q <= s_axis_tdata_i[4*SPEED_BITS-1:3*SPEED_BITS];
    end
  end

  // --- step -----------------------------------------------------------------
  // Both targets zero: stop request, integrators clear.
  assign stop = (lt_q == '0) && (rt_q == '0);

  dwps_wheel u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .update_i   (fire && !stop),
    .clear_i    (fire && stop),
    .target_i   (lt_q),
    .measured_i (lm_q),
    .cfg_i      (cfg),
    .corr_o     (lcorr)
  );

  dwps_wheel u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .update_i   (fire && !stop),
    .clear_i    (fire && stop),
    .target_i   (rt_q),
    .measured_i (rm_q),
    .cfg_i      (cfg),
    .corr_o     (rcorr)
  );

  // Sync term: mismatch between measured and target left-right difference
  assign sync_diff = (SYNC_DIFF_W'(lm_q) - SYNC_DIFF_W'(rm_q))
                   - (SYNC_DIFF_W'(lt_q) - SYNC_DIFF_W'(rt_q));
  assign sync_term = SYNC_W'($signed({1'b0, cfg.sync_gain})) * SYNC_W'(sync_diff);

  assign left_sum  = SUM_W'($signed({1'b0, cfg.base_duty})) + SUM_W'(lcorr)
                   - SUM_W'(sync_term);
  assign right_sum = SUM_W'($signed({1'b0, cfg.base_duty})) + SUM_W'(rcorr)
                   + SUM_W'(sync_term);
  assign duty_max_ext = SUM_W'($signed({1'b0, cfg.duty_max}));

  // Duty clamp to 0..duty_max; a stop step forces both drives to zero
  always_comb begin
    if (stop) begin
      left_drive_d  = '0;
      right_drive_d = '0;
      stopped_d     = 1'b1;
    end else begin
      stopped_d = 1'b0;
      if (left_sum[SUM_W-1]) begin
        left_drive_d = '0;
      end else if (left_sum > duty_max_ext) begin
        left_drive_d = cfg.duty_max;
      end else begin
        left_drive_d = left_sum[DUTY_W-1:0];
      end
      if (right_sum[SUM_W-1]) begin
        right_drive_d = '0;
      end else if (right_sum > duty_max_ext) begin
        right_drive_d = cfg.duty_max;
      end else begin
        right_drive_d = right_sum[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      left_drive_q  <= left_drive_d;
      right_drive_q <= right_drive_d;
      stopped_q     <= stopped_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({right_drive_q, left_drive_q});
  assign m_axis_tuser_o  = stopped_q;

`ifndef SYNTHESIS
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("stop result carries a non-zero drive");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with an empty result slot");

  a_fire_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("executed step produced no result");
`endif

endmodule

>>> bench/tb_dual_wheel_pi_speed_sync.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_wheel_pi_speed_sync
// Self-checking bench for the two-wheel PI speed controller. Speed requests
// go in on the request stream and a shadow predictor works out the drives
// and the stop flag for each accepted request. Every result is compared with
// the oldest prediction. Directed requests and register writes come first,
// then random traffic over a run of register settings, with random idling on
// both streams and one long output hold.
// ----------------------------------------------------------------------------
module tb_dual_wheel_pi_speed_sync;
  import dwps_pkg::*;

  localparam int SPEED_MAX    = 2 ** (SPEED_BITS - 1) - 1;
  localparam int SPEED_MIN    = -(2 ** (SPEED_BITS - 1));
  localparam int SETTLE_CYCLES = 8;       // pipeline is two deep, allow slack
  localparam int HOLD_CYCLES  = 150;      // long output hold for back-pressure
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 120;

  // Register indexes outside the map; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [SPEED_BITS-1:0] left_target;
    logic signed [SPEED_BITS-1:0] right_target;
    logic signed [SPEED_BITS-1:0] left_measured;
    logic signed [SPEED_BITS-1:0] right_measured;
  } speed_req_t;

  typedef struct {
    logic [DUTY_W-1:0] left_drive;
    logic [DUTY_W-1:0] right_drive;
    logic              stopped;
  } drive_result_t;

  // DUT connections; every input has a known value from time zero
  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_DATA_W-1:0]    s_axis_tdata_i  = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata_o;
  logic                    m_axis_tuser_o;
  logic                    cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i     = '0;

  // Shadow registers and integrators, kept as wide signed values so the
  // arithmetic below is exact
  longint gain_prop    = PROP_GAIN_RST;
  longint gain_integ   = INTEG_GAIN_RST;
  longint gain_sync    = SYNC_GAIN_RST;
  longint integ_lim    = INTEG_LIMIT_RST;
  longint duty_base    = BASE_DUTY_RST;
  longint duty_ceiling = DUTY_MAX_RST;
  longint integ_left   = 0;
  longint integ_right  = 0;

  drive_result_t expected_drives[$];

  int error_count   = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int stop_count    = 0;
  int setting_count = 0;
  bit hold_request  = 1'b0;

  dual_wheel_pi_speed_sync i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_integ(longint acc);
    if (acc > integ_lim) return integ_lim;
    if (acc < -integ_lim) return -integ_lim;
    return acc;
  endfunction

  function automatic longint clamp_duty(longint duty);
    if (duty < 0) return 0;
    if (duty > duty_ceiling) return duty_ceiling;
    return duty;
  endfunction

  // Advances the shadow integrators, so call once per accepted request
  function automatic drive_result_t predict_drive(speed_req_t req);
    longint lt, rt, lm, rm, sync_term, left_out, right_out;
    drive_result_t res;
    lt = req.left_target;
    rt = req.right_target;
    lm = req.left_measured;
    rm = req.right_measured;
    if (lt == 0 && rt == 0) begin
      // stop request: integrators cleared, both drives off
      integ_left      = 0;
      integ_right     = 0;
      res.left_drive  = '0;
      res.right_drive = '0;
      res.stopped     = 1'b1;
      return res;
    end
    // sync term uses the old speeds only, so order against the PI update
    // does not matter
    sync_term   = gain_sync * ((lm - rm) - (lt - rt));
    integ_left  = clamp_integ(integ_left + (lt - lm));
    integ_right = clamp_integ(integ_right + (rt - rm));
    left_out    = duty_base + gain_prop * (lt - lm) + gain_integ * integ_left - sync_term;
    right_out   = duty_base + gain_prop * (rt - rm) + gain_integ * integ_right + sync_term;
    res.left_drive  = DUTY_W'(clamp_duty(left_out));
    res.right_drive = DUTY_W'(clamp_duty(right_out));
    res.stopped     = 1'b0;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [SPEED_BITS-1:0] clip_speed(int v);
    if (v > SPEED_MAX) return SPEED_BITS'(SPEED_MAX);
    if (v < SPEED_MIN) return SPEED_BITS'(SPEED_MIN);
    return SPEED_BITS'(v);
  endfunction

  function automatic speed_req_t speeds(int lt, int rt, int lm, int rm);
    speed_req_t req;
    req.left_target    = clip_speed(lt);
    req.right_target   = clip_speed(rt);
    req.left_measured  = clip_speed(lm);
    req.right_measured = clip_speed(rm);
    return req;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Most requests look like a wheel tracking its target (small errors with a
  // phase bias, so integrators wind up); the rest are stops, half-stops and
  // full-range noise that reaches every bit of every field.
  function automatic speed_req_t rand_request(int bias);
    int kind, centre, lt, rt;
    speed_req_t req;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      req = speeds(0, 0, 0, 0);
      req.left_measured  = SPEED_BITS'($urandom);
      req.right_measured = SPEED_BITS'($urandom);
    end else if (kind <= 3) begin
      req.left_target    = SPEED_BITS'($urandom);
      req.right_target   = SPEED_BITS'($urandom);
      req.left_measured  = SPEED_BITS'($urandom);
      req.right_measured = SPEED_BITS'($urandom);
    end else if (kind == 4) begin
      // one wheel told to stop, the other not: still a running step
      lt = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4000) - 2000;
      rt = (lt == 0) ? $urandom_range(1, 2000) : 0;
      req = speeds(lt, rt, lt + $urandom_range(0, 100) - 50,
                   rt + $urandom_range(0, 100) - 50);
    end else begin
      centre = $urandom_range(0, 6000) - 3000;
      lt = centre + $urandom_range(0, 400) - 200;
      rt = centre + $urandom_range(0, 400) - 200;
      req = speeds(lt, rt, lt + $urandom_range(0, 100) - 50 + bias,
                   rt + $urandom_range(0, 100) - 50 + bias);
    end
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Bus tasks. All of them start and finish just after a rising edge.
  // --------------------------------------------------------------------------
  // Offers one request and waits for the handshake. tready is sampled at the
  // falling edge, where it holds the value the next rising edge will see.
  // tvalid is left high so a following request goes out without a gap.
  task automatic send_request(speed_req_t req);
    logic taken;
    s_axis_tdata_i  <= {req.right_measured, req.left_measured,
                        req.right_target, req.left_target};
    s_axis_tvalid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (taken !== 1'b1);
    expected_drives.push_back(predict_drive(req));
    sent_count++;
  endtask

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits for every outstanding result, then lets the design
  // settle so that nothing is still in flight before a register write
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // shadow copy, masked to each register's width
    case (idx)
      CFG_PROP_GAIN:   gain_prop    = value[GAIN_W-1:0];
      CFG_INTEG_GAIN:  gain_integ   = value[GAIN_W-1:0];
      CFG_SYNC_GAIN:   gain_sync    = value[GAIN_W-1:0];
      CFG_INTEG_LIMIT: integ_lim    = value[LIMIT_W-1:0];
      CFG_BASE_DUTY:   duty_base    = value[DUTY_W-1:0];
      CFG_DUTY_MAX:    duty_ceiling = value[DUTY_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [CFG_DATA_W-1:0] p_gain, logic [CFG_DATA_W-1:0] i_gain,
                                logic [CFG_DATA_W-1:0] s_gain, logic [CFG_DATA_W-1:0] limit,
                                logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] ceiling);
    write_reg(CFG_PROP_GAIN, p_gain);
    write_reg(CFG_INTEG_GAIN, i_gain);
    write_reg(CFG_SYNC_GAIN, s_gain);
    write_reg(CFG_INTEG_LIMIT, limit);
    write_reg(CFG_BASE_DUTY, base);
    write_reg(CFG_DUTY_MAX, ceiling);
    setting_count++;
  endtask

  task automatic send_random_batch(int count, int bias, bit with_gaps);
    for (int n = 0; n < count; n++) begin
      send_request(rand_request(bias));
      if (with_gaps) idle_sender(pick_gap());
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int run_left, stall_left;
    run_left   = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        // hold counted here so the sender keeps offering meanwhile
        hold_request = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(0, 24);
          stall_left = pick_gap();
        end
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // A result is taken at the rising edge that follows a falling edge with
  // tvalid and tready both high; compare it while it is stable
  always @(negedge clk_i) begin
    drive_result_t want;
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      if (expected_drives.size() == 0) begin
        $error("unexpected result: left_drive %0d, right_drive %0d, stopped %0b",
               m_axis_tdata_o[15:0], m_axis_tdata_o[31:16], m_axis_tuser_o);
        error_count++;
      end else begin
        want = expected_drives.pop_front();
        check_field("left_drive", want.left_drive, m_axis_tdata_o[15:0]);
        check_field("right_drive", want.right_drive, m_axis_tdata_o[31:16]);
        check_field("stopped", want.stopped, m_axis_tuser_o);
        checked_count++;
        if (want.stopped) stop_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset values: stop requests, ordinary steps, speed extremes that drive the
  // integrators into both clamps, and the sync term at both extremes
  task automatic test_reset_defaults();
    send_request(speeds(0, 0, 1234, -1234));
    send_request(speeds(100, 100, 90, 95));
    send_request(speeds(SPEED_MAX, SPEED_MAX, SPEED_MIN, SPEED_MIN));
    send_request(speeds(SPEED_MAX, SPEED_MAX, SPEED_MIN, SPEED_MIN));
    send_request(speeds(SPEED_MIN, SPEED_MIN, SPEED_MAX, SPEED_MAX));
    send_request(speeds(SPEED_MIN, SPEED_MAX, SPEED_MAX, SPEED_MIN));
    send_request(speeds(SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX));
    send_request(speeds(1, 0, 0, 0));
    send_request(speeds(0, 1, 0, 0));
    send_request(speeds(0, 0, 0, 0));
    send_request(speeds(50, -50, 40, -40));
    send_request(speeds(0, 0, SPEED_MIN, SPEED_MAX));
    wait_idle();
  endtask

  // Over-wide write data is cut to the register width; the spare indexes
  // must leave every register alone
  task automatic test_register_masking();
    write_reg(CFG_PROP_GAIN, 16'hFFFF);
    write_reg(CFG_INTEG_GAIN, 16'hFFFF);
    write_reg(CFG_SYNC_GAIN, 16'hFFFF);
    write_reg(CFG_INTEG_LIMIT, 16'hFFFF);
    write_reg(CFG_BASE_DUTY, 16'h0000);
    write_reg(CFG_DUTY_MAX, 16'hFFFF);
    write_reg(CFG_SPARE_LO, 16'h0000);
    write_reg(CFG_SPARE_HI, 16'h0000);
    send_request(speeds(10, 10, 9, 10));
    send_request(speeds(-7, 3, -5, 3));
    send_request(speeds(0, 0, 1, 1));
    send_request(speeds(200, -200, 190, -195));
    send_request(speeds(SPEED_MAX, 0, 0, 0));
    wait_idle();
  endtask

  // Random traffic over several settings, extremes included; every third
  // phase runs the sender without gaps
  task automatic test_random_settings();
    int ceiling, bias;
    for (int phase = 0; phase < 9; phase++) begin
      ceiling = $urandom_range(100, 65535);
      case (phase)
        0: apply_settings(PROP_GAIN_RST, INTEG_GAIN_RST, SYNC_GAIN_RST,
                          INTEG_LIMIT_RST, BASE_DUTY_RST, DUTY_MAX_RST);
        1: apply_settings(16'h03FF, 16'h03FF, 16'h03FF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        2: apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        3: apply_settings($urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(0, 4),
                          16'h0000, ceiling / 2, ceiling);
        4: apply_settings($urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(0, 4),
                          $urandom_range(0, 2000), 16'hFFFF, 16'h0000);
        7: apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        8: apply_settings($urandom_range(512, 1023), $urandom_range(512, 1023),
                          $urandom_range(512, 1023), $urandom_range(16384, 32767),
                          16'h8000, 16'hFFFF);
        default: apply_settings($urandom_range(0, 8), $urandom_range(0, 4),
                                $urandom_range(0, 4), $urandom_range(0, 2000),
                                $urandom_range(0, ceiling), ceiling);
      endcase
      bias = $urandom_range(0, 60) - 30;
      send_random_batch(PHASE_ITEMS, bias, phase % 3 != 2);
      wait_idle();
    end
  endtask

  // Output held for a long stretch while requests keep coming back-to-back:
  // the pipeline fills and the input must stall without losing anything
  task automatic test_output_backpressure();
    apply_settings($urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(0, 4),
                   $urandom_range(0, 2000), 16'd20000, 16'd40000);
    hold_request = 1'b1;
    send_random_batch(40, 0, 1'b0);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_masking();
    test_random_settings();
    test_output_backpressure();

    $display("run covered %0d requests under %0d register settings plus reset values",
             sent_count, setting_count);
    $display("%0d results compared, %0d of them stops, %0d mismatches",
             checked_count, stop_count, error_count);
    if (error_count == 0) begin
      $display("tb_dual_wheel_pi_speed_sync: done, clean");
    end else begin
      $display("tb_dual_wheel_pi_speed_sync: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, expected_drives.size());
    $display("tb_dual_wheel_pi_speed_sync: done, errors");
    $finish;
  end

endmodule

>>> dual_wheel_pi_speed_sync.f
src/dwps_pkg.sv
src/dwps_cfg.sv
src/dwps_wheel.sv
src/dual_wheel_pi_speed_sync.sv
bench/tb_dual_wheel_pi_speed_sync.sv
